// ----- hw/rtl/dq_pkg.sv -----
// Shared types and constants for the double-ended queue with search.
// No dependencies; used by dq_cell and double_ended_queue_with_search.
`timescale 1ns / 1ps

package dq_pkg;

   // Queue geometry
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Item field widths
   localparam int REQ_W       = 3;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 8;
   localparam int DATA_OUT_W  = 32;
   localparam int FOUND_W     = 4;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 5;

   localparam int IN_FIELDS_W  = VALUE_W + POS_W;
   localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
   localparam int OUT_FIELDS_W = DATA_OUT_W + FOUND_W + STATUS_W + COUNT_W;
   localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH_BACK  = 3'd0,
      REQ_PUSH_FRONT = 3'd1,
      REQ_POP_BACK   = 3'd2,
      REQ_POP_FRONT  = 3'd3,
      REQ_READ       = 3'd4,
      REQ_FIND       = 3'd5
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_RANGE     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic                    live;
      logic [DATA_WIDTH-1:0]   word;
   } cell_ctl_type;

endpackage

// ----- hw/rtl/dq_cell.sv -----
// One storage cell of the deque chain: holds one word, shifts to/from neighbors.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_cell (
   input  logic                            clock,
   input  dq_pkg::cell_ctl_type            ctl,
   input  logic [dq_pkg::DATA_WIDTH-1:0]   prev_data,
   input  logic [dq_pkg::DATA_WIDTH-1:0]   next_data,
   output logic [dq_pkg::DATA_WIDTH-1:0]   data_out,
   output logic                            hit
);

   logic [dq_pkg::DATA_WIDTH-1:0] data_ff;
   logic [dq_pkg::DATA_WIDTH-1:0] data_in;

   always_comb begin
      case (ctl.op)
         dq_pkg::CELL_HOLD:      data_in = data_ff;
         dq_pkg::CELL_LOAD:      data_in = ctl.word;
         dq_pkg::CELL_FROM_PREV: data_in = prev_data;
         dq_pkg::CELL_FROM_NEXT: data_in = next_data;
         default:                data_in = data_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   // match only on live entries
   assign hit      = ctl.live && (data_ff == ctl.word);

endmodule

// ----- hw/rtl/double_ended_queue_with_search.sv -----
// Top level of the double-ended queue with indexed read and search.
// Depends on dq_pkg and dq_cell.
`timescale 1ns / 1ps

// Usage
//  - req channel: one item per request. req_tuser carries the request kind
//    (push back, push front, pop back, pop front, read index, find);
//    req_tdata carries the value word and the read position.
//  - rsp channel: exactly one item per request, in order: popped or read
//    word, first matching position, status and the entry count after the
//    request.
//  - Storage is a row of DEPTH cells, cell 0 always the front. Push front
//    and pop front shift the whole row by one; push back loads the cell at
//    the current count. Find compares every cell against the value at once.
//  - The response is registered and appears in the cycle after the request item
//    is accepted. Throughput: 1 item per cycle while the rsp side is not stalled;
//    the row of cells updates as each item is accepted, so nothing limits the rate beyond the response register.
//  - Stall: outside reset, req_tready is high while the response register is
//    empty or is being taken in the same cycle; a stalled rsp side holds its
//    item and backpressures the request side.
//  - Reset (synchronous, active high): entry count and response valid clear.
//    Cell contents are not cleared; cells beyond the count are never used.
module double_ended_queue_with_search (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dq_pkg::IN_TDATA_W-1:0]   req_tdata,  // value[31:0], position[39:32]
   input  logic [dq_pkg::REQ_W-1:0]        req_tuser,  // req_type[2:0]
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dq_pkg::OUT_TDATA_W-1:0]  rsp_tdata   // data_out[31:0], found_position[35:32],
                                                       // status[38:36], entry_count[43:39]
);

   localparam int CMP_W = dq_pkg::POS_W + 1;

   // request fields
   logic [dq_pkg::VALUE_W-1:0]    req_value;
   logic [dq_pkg::POS_W-1:0]      req_position;
   logic [dq_pkg::DATA_WIDTH-1:0] req_word;
   logic                          req_fire;

   assign req_value    = req_tdata[dq_pkg::VALUE_W-1:0];
   assign req_position = req_tdata[dq_pkg::VALUE_W +: dq_pkg::POS_W];
   assign req_word     = req_value[dq_pkg::DATA_WIDTH-1:0];
   assign req_fire     = req_tvalid && req_tready;

   // control state
   logic [dq_pkg::CNT_W-1:0] count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [dq_pkg::OUT_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic is_full, is_empty, pos_ok;
   assign is_full  = (count_ff == dq_pkg::CNT_W'(dq_pkg::DEPTH));
   assign is_empty = (count_ff == '0);
   assign pos_ok   = CMP_W'(req_position) < CMP_W'(count_ff);

   // cell row
   dq_pkg::cell_ctl_type          cell_ctl  [dq_pkg::DEPTH];
   logic [dq_pkg::DATA_WIDTH-1:0] cell_data [dq_pkg::DEPTH];
   logic [dq_pkg::DEPTH-1:0]      cell_hit;

   always_comb begin
      for (int i = 0; i < dq_pkg::DEPTH; i++) begin
         cell_ctl[i].word = req_word;
         cell_ctl[i].live = dq_pkg::CNT_W'(i) < count_ff;
         cell_ctl[i].op   = dq_pkg::CELL_HOLD;
         if (req_fire) begin
            case (req_tuser)
               dq_pkg::REQ_PUSH_FRONT: begin
                  if (!is_full) begin
                     cell_ctl[i].op = (i == 0) ? dq_pkg::CELL_LOAD : dq_pkg::CELL_FROM_PREV;
                  end
               end
               dq_pkg::REQ_PUSH_BACK: begin
                  if (!is_full && (dq_pkg::CNT_W'(i) == count_ff)) begin
                     cell_ctl[i].op = dq_pkg::CELL_LOAD;
                  end
               end
               dq_pkg::REQ_POP_FRONT: begin
                  if (!is_empty) begin
                     cell_ctl[i].op = dq_pkg::CELL_FROM_NEXT;
                  end
               end
               default: cell_ctl[i].op = dq_pkg::CELL_HOLD;
            endcase
         end
      end
   end

   for (genvar g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
      // row ends feed back their own word; cell 0 never selects it, the last cell keeps its word on pop front
      dq_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[g]),
         .prev_data ((g == 0) ? cell_data[g] : cell_data[(g == 0) ? 0 : g - 1]),
         .next_data ((g == dq_pkg::DEPTH - 1) ? cell_data[g] :
                     cell_data[(g == dq_pkg::DEPTH - 1) ? g : g + 1]),
         .data_out  (cell_data[g]),
         .hit       (cell_hit[g])
      );
   end

   // single read port: pop back reads the last entry, read index its position
   logic [dq_pkg::IDX_W-1:0]      rd_idx;
   logic [dq_pkg::CNT_W-1:0]      count_m1;
   logic [dq_pkg::DATA_WIDTH-1:0] rd_word;

   assign count_m1 = count_ff - dq_pkg::CNT_W'(1);
   assign rd_idx   = (req_tuser == dq_pkg::REQ_POP_BACK) ? count_m1[dq_pkg::IDX_W-1:0]
                                                          : req_position[dq_pkg::IDX_W-1:0];
   assign rd_word  = cell_data[rd_idx];

   // first hit from the front
   logic                     hit_any;
   logic [dq_pkg::IDX_W-1:0] hit_idx;

   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = dq_pkg::DEPTH - 1; i >= 0; i--) begin
         if (cell_hit[i]) begin
            hit_any = 1'b1;
            hit_idx = dq_pkg::IDX_W'(i);
         end
      end
   end

   // result and count update
   logic [dq_pkg::DATA_WIDTH-1:0] res_data;
   logic [dq_pkg::IDX_W-1:0]      res_found;
   dq_pkg::status_type            res_status;

   always_comb begin
      res_data   = '0;
      res_found  = '0;
      res_status = dq_pkg::ST_OK;
      count_in   = count_ff;
      case (req_tuser)
         dq_pkg::REQ_PUSH_BACK, dq_pkg::REQ_PUSH_FRONT: begin
            if (is_full) begin
               res_status = dq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + dq_pkg::CNT_W'(1);
            end
         end
         dq_pkg::REQ_POP_BACK: begin
            if (is_empty) begin
               res_status = dq_pkg::ST_EMPTY;
            end else begin
               res_data = rd_word;
               count_in = count_m1;
            end
         end
         dq_pkg::REQ_POP_FRONT: begin
            if (is_empty) begin
               res_status = dq_pkg::ST_EMPTY;
            end else begin
               res_data = cell_data[0];
               count_in = count_m1;
            end
         end
         dq_pkg::REQ_READ: begin
            if (pos_ok) begin
               res_data = rd_word;
            end else begin
               res_status = dq_pkg::ST_RANGE;
            end
         end
         dq_pkg::REQ_FIND: begin
            if (hit_any) begin
               res_found = hit_idx;
            end else begin
               res_status = dq_pkg::ST_NOT_FOUND;
            end
         end
         default: res_status = dq_pkg::ST_OK;
      endcase
      if (!req_fire) begin
         count_in = count_ff;
      end
   end

   assign rsp_data_in = dq_pkg::OUT_TDATA_W'({dq_pkg::COUNT_W'(count_in),
                                              res_status,
                                              dq_pkg::FOUND_W'(res_found),
                                              dq_pkg::DATA_OUT_W'(res_data)});

   // no item is taken while reset is high
   assign req_tready   = !reset && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
      else $error("entry count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == dq_pkg::REQ_PUSH_BACK) && !is_full
      |=> count_ff == $past(count_ff) + dq_pkg::CNT_W'(1))
      else $error("push back did not grow the queue");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == dq_pkg::REQ_POP_FRONT) && !is_empty
      |=> count_ff == $past(count_ff) - dq_pkg::CNT_W'(1))
      else $error("pop front did not shrink the queue");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> count_ff == $past(count_ff))
      else $error("entry count changed without a request");

endmodule
